### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer package
// Screen geometry, codes, state and datapath op types shared by the console
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 2 * CHAR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int FLOOR_W    = 11;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BS    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_FLOOR = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd15;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT_CHK,
    S_BS,
    S_CLEAR,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_NL_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_CLEAR,
    OP_SCROLL,
    OP_FILL,
    OP_NEWLINE,
    OP_PUT,
    OP_BS
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
    logic   emit;
  } ctl_t;

  typedef struct packed {
    logic char_nl;
    logic col_full;
    logic row_bottom;
    logic bs_ok;
    logic scroll_end;
    logic sweep_last;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Put, backspace, read: the command is registered on accept, handled in its
// own state, then S_EMIT raises the registered done strobe; a new command is
// taken only in S_IDLE. A put that wraps a full row passes S_PUT_CHK again.
// Clear: one cell memory write per cycle. New line on the bottom row: row
// copy and blank fill through the single read and single write port of the
// cell memory. After rst the block is busy for a clearing pass; configuration
// writes are taken at any time. done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [CHAR_W-1:0]     char_code,
  input  wire logic [ROW_W-1:0]      cell_row,
  input  wire logic [COL_W-1:0]      cell_col,
  output logic                       done,
  output logic [CHAR_W-1:0]          read_char,
  output logic [CHAR_W-1:0]          read_color,
  output logic [ROW_W-1:0]           cursor_row,
  output logic [COL_W-1:0]           cursor_col,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t    ctl;
  status_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .command    (command),
    .char_code  (char_code),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .read_char  (read_char),
    .read_color (read_color),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

endmodule

`default_nettype wire

### rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console controller
// Sequences reset clearing, put, new line with scroll, backspace, clear and
// read transactions, issuing one datapath op per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] command,
  input  wire status_t          sts,
  output ctl_t                  ctl,
  output logic                  busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.op     = OP_NONE;
    ctl.emit   = 1'b0;
    busy       = (state != S_IDLE);
    case (state)
      S_INIT: begin
        ctl.op = OP_INIT;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (command)
            CMD_PUT:   state_next = S_PUT_CHK;
            CMD_BS:    state_next = S_BS;
            CMD_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_READ;
          endcase
        end
      end
      S_PUT_CHK: begin
        if (sts.char_nl || sts.col_full) begin
          if (sts.row_bottom) begin
            state_next = S_SCROLL;
          end else begin
            ctl.op     = OP_NEWLINE;
            state_next = sts.char_nl ? S_EMIT : S_PUT_CHK;
          end
        end else begin
          ctl.op     = OP_PUT;
          state_next = S_EMIT;
        end
      end
      S_BS: begin
        if (sts.bs_ok) ctl.op = OP_BS;
        state_next = S_EMIT;
      end
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (sts.sweep_last) state_next = S_EMIT;
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_SCROLL: begin
        ctl.op = OP_SCROLL;
        if (sts.scroll_end) state_next = S_FILL;
      end
      S_FILL: begin
        ctl.op = OP_FILL;
        if (sts.sweep_last) state_next = S_NL_FIN;
      end
      S_NL_FIN: begin
        ctl.op     = OP_NEWLINE;
        state_next = sts.char_nl ? S_EMIT : S_PUT_CHK;
      end
      S_EMIT: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: console datapath
// Cell memory, cursor and last written position, sweep counter for clearing
// and scrolling, configuration registers and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  ctl,
  output status_t                    sts,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [CHAR_W-1:0]     char_code,
  input  wire logic [ROW_W-1:0]      cell_row,
  input  wire logic [COL_W-1:0]      cell_col,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output logic [CHAR_W-1:0]          read_char,
  output logic [CHAR_W-1:0]          read_color,
  output logic [ROW_W-1:0]           cursor_row,
  output logic [COL_W-1:0]           cursor_col
);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] SCROLL_TOP = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;

  logic [CMD_W-1:0]   cmd_q;
  logic [CHAR_W-1:0]  char_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;

  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [ADDR_W-1:0]  last_written;
  logic [ADDR_W-1:0]  sweep;
  logic [CHAR_W-1:0]  text_color;
  logic [FLOOR_W-1:0] erase_floor;

  logic [ADDR_W-1:0]  pos_cur;
  logic [ADDR_W:0]    rd_pos;
  logic               in_range;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [CELL_W-1:0]  blank;

  assign blank    = {text_color, SPACE_CODE};
  assign pos_cur  = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);
  assign rd_pos   = (ADDR_W + 1)'(row_q) * (ADDR_W + 1)'(COLS) + (ADDR_W + 1)'(col_q);
  assign in_range = (32'(row_q) < ROWS) && (32'(col_q) < COLS);

  assign sts.char_nl    = (char_q == NEWLINE_CODE);
  assign sts.col_full   = (cur_col == COL_W'(COLS));
  assign sts.row_bottom = (cur_row == ROW_W'(ROWS - 1));
  assign sts.bs_ok      = (cur_col != '0) && (FLOOR_W'(last_written) > erase_floor);
  assign sts.scroll_end = (sweep == SCROLL_TOP);
  assign sts.sweep_last = (sweep == LAST_CELL);

  always_comb begin
    we    = 1'b0;
    waddr = sweep;
    wdata = blank;
    case (ctl.op)
      OP_INIT: begin
        we    = 1'b1;
        wdata = {RESET_COLOR, SPACE_CODE};
      end
      OP_CLEAR, OP_FILL: begin
        we = 1'b1;
      end
      OP_SCROLL: begin
        we    = (sweep != '0);
        waddr = sweep - 1'b1;
        wdata = rdata;
      end
      OP_PUT: begin
        we    = 1'b1;
        waddr = pos_cur;
        wdata = {text_color, char_q};
      end
      OP_BS: begin
        we    = 1'b1;
        waddr = pos_cur - 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ctl.op == OP_SCROLL && !sts.scroll_end) begin
      raddr = sweep + COLS_A;
    end else if (in_range) begin
      raddr = rd_pos[ADDR_W-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      char_q <= char_code;
      row_q  <= cell_row;
      col_q  <= cell_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= RESET_COLOR;
      erase_floor <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_COLOR:  text_color  <= cfg_data[CHAR_W-1:0];
        CFG_ERASE_FLOOR: erase_floor <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (ctl.load) begin
      sweep <= '0;
    end else begin
      case (ctl.op)
        OP_INIT, OP_CLEAR, OP_FILL: sweep <= sweep + 1'b1;
        OP_SCROLL: if (!sts.scroll_end) sweep <= sweep + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row      <= '0;
      cur_col      <= '0;
      last_written <= '0;
    end else begin
      case (ctl.op)
        OP_NEWLINE: begin
          cur_col <= '0;
          if (!sts.row_bottom) cur_row <= cur_row + 1'b1;
        end
        OP_PUT: begin
          last_written <= pos_cur;
          cur_col      <= cur_col + 1'b1;
        end
        OP_BS: begin
          last_written <= last_written - 1'b1;
          cur_col      <= cur_col - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      if (cmd_q == CMD_READ && in_range) begin
        read_char  <= rdata[CHAR_W-1:0];
        read_color <= rdata[CELL_W-1:CHAR_W];
      end else begin
        read_char  <= '0;
        read_color <= '0;
      end
      cursor_row <= cur_row;
      cursor_col <= cur_col;
    end
  end

endmodule

`default_nettype wire

### bench/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// A short table of directed commands covers reads after reset, out-of-range
// reads, puts of extreme characters, backspace at column zero and at the
// floor, new line and clear. Random phases of text lines, backspaces,
// reads, new lines and clears follow, each under its own colour and erase
// floor. Each result is checked against its directed entry or a shadow screen.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } screen_report_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              known;
    screen_report_t    want;
  } directed_step_t;

  localparam screen_report_t NO_REPORT = '0;
  localparam int PHASE_ITEMS = 180;
  localparam int DIRECTED_N = 21;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ROW_W-1:0] cell_row = '0;
  logic [COL_W-1:0] cell_col = '0;
  logic done;
  logic [CHAR_W-1:0] read_char;
  logic [CHAR_W-1:0] read_color;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  text_console_writer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .char_code(char_code), .cell_row(cell_row), .cell_col(cell_col),
    .done(done), .read_char(read_char), .read_color(read_color),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow screen
  logic [CELL_W-1:0] shadow_cells [CELLS];
  logic [ROW_W-1:0]  shadow_row = '0;
  logic [COL_W-1:0]  shadow_col = '0;
  logic [ADDR_W-1:0] shadow_last = '0;
  logic [CHAR_W-1:0] shadow_color = RESET_COLOR;
  logic [FLOOR_W-1:0] shadow_floor = '0;

  screen_report_t pending_reports [$];
  screen_report_t head;
  int fail_count = 0;
  int results_seen = 0;
  int scroll_count = 0;
  int sent_total = 0;
  int sent_count [4] = '{0, 0, 0, 0};
  int sender_idle_pct = 36;

  directed_step_t directed_steps [DIRECTED_N] = '{
    '{CMD_READ, 8'h00, 5'd0, 7'd0, 1'b1, '{SPACE_CODE, RESET_COLOR, 5'd0, 7'd0}},
    '{CMD_READ, 8'hFF, 5'd24, 7'd79, 1'b1, '{SPACE_CODE, RESET_COLOR, 5'd0, 7'd0}},
    '{CMD_READ, 8'h00, 5'd31, 7'd127, 1'b1, NO_REPORT},
    '{CMD_READ, 8'h00, 5'd0, 7'd80, 1'b1, NO_REPORT},
    '{CMD_READ, 8'h00, 5'd25, 7'd0, 1'b1, NO_REPORT},
    '{CMD_BS, 8'hFF, 5'd31, 7'd127, 1'b1, NO_REPORT},
    '{CMD_PUT, 8'h41, 5'd31, 7'd127, 1'b1, '{8'd0, 8'd0, 5'd0, 7'd1}},
    '{CMD_PUT, 8'hFF, 5'd0, 7'd0, 1'b1, '{8'd0, 8'd0, 5'd0, 7'd2}},
    '{CMD_PUT, 8'h00, 5'd0, 7'd0, 1'b1, '{8'd0, 8'd0, 5'd0, 7'd3}},
    '{CMD_READ, 8'h00, 5'd0, 7'd0, 1'b1, '{8'h41, RESET_COLOR, 5'd0, 7'd3}},
    '{CMD_READ, 8'h00, 5'd0, 7'd1, 1'b1, '{8'hFF, RESET_COLOR, 5'd0, 7'd3}},
    '{CMD_BS, 8'h00, 5'd0, 7'd0, 1'b0, NO_REPORT},
    '{CMD_BS, 8'h00, 5'd0, 7'd0, 1'b0, NO_REPORT},
    '{CMD_BS, 8'h00, 5'd0, 7'd0, 1'b0, NO_REPORT},
    '{CMD_READ, 8'h00, 5'd0, 7'd1, 1'b0, NO_REPORT},
    '{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b1, '{8'd0, 8'd0, 5'd1, 7'd0}},
    '{CMD_PUT, 8'h7E, 5'd0, 7'd0, 1'b0, NO_REPORT},
    '{CMD_CLEAR, 8'h55, 5'd10, 7'd42, 1'b0, NO_REPORT},
    '{CMD_READ, 8'h00, 5'd1, 7'd0, 1'b0, NO_REPORT},
    '{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0, NO_REPORT},
    '{CMD_READ, 8'h00, 5'd24, 7'd0, 1'b0, NO_REPORT}
  };

  logic [CMD_W-1:0] cheap_cmds [3] = '{CMD_PUT, CMD_BS, CMD_READ};

  initial begin
    foreach (shadow_cells[i]) shadow_cells[i] = {RESET_COLOR, SPACE_CODE};
  end

  function automatic void advance_line();
    shadow_col = '0;
    if (shadow_row + 1 < ROWS) begin
      shadow_row++;
    end else begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_color, SPACE_CODE};
      scroll_count++;
    end
  endfunction

  function automatic screen_report_t predict_console(input logic [CMD_W-1:0] cmd,
      input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    screen_report_t rep;
    int pos;
    rep = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == NEWLINE_CODE) begin
          advance_line();
        end else begin
          if (shadow_col >= COLS) advance_line();
          pos = shadow_row * COLS + shadow_col;
          shadow_cells[pos] = {shadow_color, ch};
          shadow_last = ADDR_W'(pos);
          shadow_col++;
        end
      end
      CMD_BS: begin
        if (shadow_col != 0 && shadow_last > shadow_floor) begin
          shadow_col--;
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, SPACE_CODE};
          shadow_last--;
        end
      end
      CMD_CLEAR: begin
        foreach (shadow_cells[i]) shadow_cells[i] = {shadow_color, SPACE_CODE};
      end
      CMD_READ: begin
        if (r < ROWS && c < COLS) begin
          pos = r * COLS + c;
          rep.ch = shadow_cells[pos][CHAR_W-1:0];
          rep.color = shadow_cells[pos][CELL_W-1:CHAR_W];
        end
      end
    endcase
    rep.row = shadow_row;
    rep.col = shadow_col;
    return rep;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    if ($urandom_range(0, 9) < 7) return CHAR_W'($urandom_range(32, 126));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic report_error(input string msg);
    if (fail_count < 50) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // results are checked in order against the oldest pending report
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        report_error("result with no transaction pending");
      end else begin
        head = pending_reports.pop_front();
        check_field("read_char", int'(read_char), int'(head.ch));
        check_field("read_color", int'(read_color), int'(head.color));
        check_field("cursor_row", int'(cursor_row), int'(head.row));
        check_field("cursor_col", int'(cursor_col), int'(head.col));
        results_seen++;
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
      input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c, input logic known,
      input screen_report_t want);
    screen_report_t predicted;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start <= 1'b1;
    command <= cmd;
    char_code <= ch;
    cell_row <= r;
    cell_col <= c;
    do @(posedge clk); while (busy);
    predicted = predict_console(cmd, ch, r, c);
    pending_reports.push_back(known ? want : predicted);
    sent_count[cmd]++;
    sent_total++;
  endtask

  task automatic settle(input int extra);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TEXT_COLOR) shadow_color = value[CHAR_W-1:0];
    else shadow_floor = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int pick;
    int len;
    int phase_start;
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      send_command(directed_steps[i].cmd, directed_steps[i].ch, directed_steps[i].row,
                   directed_steps[i].col, directed_steps[i].known, directed_steps[i].want);
    settle(8);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          write_register(CFG_TEXT_COLOR, 11'd255);
          write_register(CFG_ERASE_FLOOR, 11'd0);
          sender_idle_pct = 36;
        end
        1: begin
          write_register(CFG_TEXT_COLOR, 11'd0);
          write_register(CFG_ERASE_FLOOR, 11'd1999);
          sender_idle_pct = 80;
        end
        default: begin
          write_register(CFG_TEXT_COLOR, CFG_DATA_W'($urandom_range(1, 254)));
          write_register(CFG_ERASE_FLOOR, CFG_DATA_W'($urandom_range(0, 1999)));
          sender_idle_pct = 0;
        end
      endcase
      phase_start = sent_total;
      while (sent_total - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // a line of text, sometimes long enough to wrap
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 12);
          repeat (len)
            send_command(CMD_PUT, rand_char(), ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
          if ($urandom_range(0, 9) < 7)
            send_command(CMD_PUT, NEWLINE_CODE, ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
        end else if (pick < 64) begin
          repeat ($urandom_range(1, 6))
            send_command(CMD_BS, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
        end else if (pick < 84) begin
          repeat ($urandom_range(1, 4)) begin
            k = $urandom_range(0, 9);
            if (k < 5)
              send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), shadow_row,
                           COL_W'($urandom_range(0, 79)), 1'b0, NO_REPORT);
            else if (k < 8)
              send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                           ROW_W'($urandom_range(0, 24)),
                           COL_W'($urandom_range(0, 79)), 1'b0, NO_REPORT);
            else
              send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                           ROW_W'($urandom_range(0, 31)),
                           COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
          end
        end else if (pick < 91) begin
          repeat ($urandom_range(1, 5))
            send_command(CMD_PUT, NEWLINE_CODE, ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
        end else if (pick < 94) begin
          send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                       ROW_W'($urandom_range(0, 31)),
                       COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
        end else begin
          // noise: any cheap command with raw field values
          repeat ($urandom_range(1, 3))
            send_command(cheap_cmds[$urandom_range(0, 2)], CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 127)), 1'b0, NO_REPORT);
        end
        if ($urandom_range(0, 29) == 0) settle(2);
      end
      settle(8);
    end

    settle(16);
    $display("%0d transactions: %0d put, %0d backspace, %0d clear, %0d read; %0d results checked",
             sent_total, sent_count[CMD_PUT], sent_count[CMD_BS], sent_count[CMD_CLEAR],
             sent_count[CMD_READ], results_seen);
    $display("%0d bottom-row scrolls, colours 15/255/0/random, erase floors 0/1999/random",
             scroll_count);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #48000000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
